/* hw/rtl/srlc_pkg.sv */
// Shared types and constants for the sparse row length cutoff block.
package srlc_pkg;

  localparam int SRLC_ROWS     = 1024;
  localparam int SRLC_POS_W    = 16;
  localparam int SRLC_MAX_W    = SRLC_POS_W + 1;
  localparam int SRLC_EPOCH_W  = 8;
  localparam int SRLC_LEAD_W   = 10;
  localparam int SRLC_INNER_W  = 11;
  localparam int SRLC_TAIL_W   = 32;
  localparam int SRLC_VALUE_W  = 64;
  localparam int SRLC_RID_W    = SRLC_LEAD_W + SRLC_INNER_W + 1;
  localparam int SRLC_CFG_W    = 16;
  localparam int SRLC_CFG_IDX_W = 2;
  localparam int SRLC_IN_W     = 136;
  localparam int SRLC_OUT_W    = 136;

  typedef logic [1:0] srlc_op_t;

  localparam srlc_op_t OP_BEGIN   = 2'd0;
  localparam srlc_op_t OP_MEASURE = 2'd1;
  localparam srlc_op_t OP_EMIT    = 2'd2;

  localparam logic [SRLC_CFG_IDX_W-1:0] CFG_CUT_LENGTH = 2'd0;
  localparam logic [SRLC_CFG_IDX_W-1:0] CFG_SIDE_LEFT  = 2'd1;
  localparam logic [SRLC_CFG_IDX_W-1:0] CFG_AXIS_TWO   = 2'd2;
  localparam logic [SRLC_CFG_IDX_W-1:0] CFG_INNER_SIZE = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture input transaction
    logic calc;   // form row id
    logic rd;     // read row table
    logic exec;   // update row / produce result
    logic bump;   // advance epoch
    logic clr;    // clear one row table entry
  } srlc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    srlc_op_t op;
    logic     in_range;
    logic     wrap;
    logic     clr_last;
    logic     out_busy;
  } srlc_sts_t;

endpackage

/* hw/rtl/srlc_ctrl.sv */
// Sequencer for the sparse row length cutoff block.
module srlc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  srlc_pkg::srlc_sts_t sts,
  output srlc_pkg::srlc_cmd_t cmd
);
  import srlc_pkg::*;

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_EX   = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       calc_r, calc_nxt;   // cycle after accept, row id being formed

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      calc_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      calc_r  <= calc_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    calc_nxt  = 1'b0;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (calc_r) begin
          cmd.calc = 1'b1;
          priority if (sts.op == OP_BEGIN) begin
            cmd.bump = 1'b1;
            if (sts.wrap) state_nxt = ST_CLR;
          end else if (sts.op == OP_MEASURE || sts.op == OP_EMIT) begin
            state_nxt = ST_RD;
          end else begin
            state_nxt = ST_IDLE;   // unknown opcode: dropped
          end
        end else begin
          in_tready = 1'b1;
          if (in_tvalid) begin
            cmd.load = 1'b1;
            calc_nxt = 1'b1;
          end
        end
      end
      ST_RD: begin
        if (sts.in_range) begin
          cmd.rd    = 1'b1;
          state_nxt = ST_EX;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EX: begin
        if (!(sts.op == OP_EMIT && sts.out_busy)) begin
          cmd.exec  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLR;
    endcase
  end

endmodule

/* hw/rtl/srlc_dp.sv */
// Datapath: input capture, row table, epoch, cutoff logic and output register.
module srlc_dp #(
  parameter int ROWS = srlc_pkg::SRLC_ROWS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [srlc_pkg::SRLC_IN_W-1:0]      in_tdata,
  input  srlc_pkg::srlc_op_t                  in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [srlc_pkg::SRLC_OUT_W-1:0]     out_tdata,
  input  logic                                cfg_we,
  input  logic [srlc_pkg::SRLC_CFG_IDX_W-1:0] cfg_addr,
  input  logic [srlc_pkg::SRLC_CFG_W-1:0]     cfg_wdata,
  input  srlc_pkg::srlc_cmd_t                 cmd,
  output srlc_pkg::srlc_sts_t                 sts
);
  import srlc_pkg::*;

  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ENT_W = SRLC_EPOCH_W + SRLC_MAX_W;

  // configuration
  logic [SRLC_POS_W-1:0]   cut_r;
  logic                    side_left_r;
  logic                    axis_two_r;
  logic [SRLC_INNER_W-1:0] inner_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cut_r       <= '0;
      side_left_r <= 1'b0;
      axis_two_r  <= 1'b0;
      inner_r     <= SRLC_INNER_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_CUT_LENGTH: cut_r       <= cfg_wdata;
        CFG_SIDE_LEFT:  side_left_r <= cfg_wdata[0];
        CFG_AXIS_TWO:   axis_two_r  <= cfg_wdata[0];
        CFG_INNER_SIZE: inner_r     <= cfg_wdata[SRLC_INNER_W-1:0];
        default: ;
      endcase
    end
  end

  // input capture
  srlc_op_t                op_r;
  logic [SRLC_LEAD_W-1:0]  lead0_r, lead1_r;
  logic [SRLC_POS_W-1:0]   pos_r;
  logic [SRLC_TAIL_W-1:0]  tail_r;
  logic [SRLC_VALUE_W-1:0] value_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_tuser;
      lead0_r <= in_tdata[9:0];
      lead1_r <= in_tdata[19:10];
      pos_r   <= in_tdata[35:20];
      tail_r  <= in_tdata[67:36];
      value_r <= in_tdata[131:68];
    end
  end

  // row id
  logic [SRLC_LEAD_W+SRLC_INNER_W-1:0] prod;
  logic [SRLC_RID_W-1:0]               rid;
  logic [ROW_W-1:0]                    row_r;
  logic                                in_range_r;

  assign prod = {{SRLC_INNER_W{1'b0}}, lead0_r} * {{SRLC_LEAD_W{1'b0}}, inner_r};
  assign rid  = axis_two_r ? ({1'b0, prod} + SRLC_RID_W'(lead1_r)) : SRLC_RID_W'(lead0_r);

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      row_r      <= ROW_W'(rid);
      in_range_r <= (32'(rid) < 32'(ROWS));
    end
  end

  // epoch and clearing sweep
  logic [SRLC_EPOCH_W-1:0] epoch_r;
  logic [ROW_W-1:0]        clr_cnt_r;
  logic                    clr_last;

  assign clr_last = (32'(clr_cnt_r) == 32'(ROWS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r   <= '0;
      clr_cnt_r <= '0;
    end else begin
      if (cmd.bump) epoch_r <= epoch_r + SRLC_EPOCH_W'(1);
      if (cmd.clr) clr_cnt_r <= clr_last ? '0 : clr_cnt_r + ROW_W'(1);
    end
  end

  // row table {tag, max}
  logic [ENT_W-1:0]        mem [ROWS];
  logic [ENT_W-1:0]        rd_data_r;
  logic                    wr_en;
  logic [ROW_W-1:0]        wr_addr;
  logic [ENT_W-1:0]        wr_data;

  // cutoff
  logic [SRLC_MAX_W-1:0] mx, pos1, meas_max, cut17, sum;
  logic                  keep;
  logic [SRLC_POS_W-1:0] new_pos;

  assign mx    = (rd_data_r[ENT_W-1 -: SRLC_EPOCH_W] == epoch_r) ?
                 rd_data_r[SRLC_MAX_W-1:0] : '0;
  assign pos1  = {1'b0, pos_r} + SRLC_MAX_W'(1);
  assign meas_max = (pos1 > mx) ? pos1 : mx;
  assign cut17 = {1'b0, cut_r};
  assign sum   = {1'b0, pos_r} + cut17;

  always_comb begin
    keep    = 1'b1;
    new_pos = pos_r;
    priority if (mx <= cut17) begin
      keep = 1'b1;
    end else if (!side_left_r) begin
      keep = (pos_r < cut_r);
    end else begin
      keep    = (sum >= mx);
      new_pos = SRLC_POS_W'(sum - mx);
    end
  end

  assign wr_en   = cmd.clr || (cmd.exec && op_r == OP_MEASURE);
  assign wr_addr = cmd.clr ? clr_cnt_r : row_r;
  assign wr_data = cmd.clr ? '0 : {epoch_r, meas_max};

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd) rd_data_r <= mem[row_r];
  end

  // output register
  logic                  out_valid_r;
  logic [SRLC_OUT_W-1:0] out_data_r;
  logic                  emit_now;

  assign emit_now = cmd.exec && op_r == OP_EMIT && keep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_now) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_now) out_data_r <= {4'b0, value_r, tail_r, new_pos, lead1_r, lead0_r};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign sts.op       = op_r;
  assign sts.in_range = in_range_r;
  assign sts.wrap     = (epoch_r == {SRLC_EPOCH_W{1'b1}});
  assign sts.clr_last = clr_last;
  assign sts.out_busy = out_valid_r && !out_tready;

endmodule

/* hw/rtl/sparse_row_length_cutoff.sv */
// Top level of the sparse row length cutoff block.
//
// Usage:
//   in_*  : command/entry stream. in_tuser = opcode (begin, measure, emit).
//           A begin opens a tensor, measure entries record each row's largest
//           pos+1, emit entries are presented again and come out trimmed.
//   out_* : kept emit entries with the remapped cutoff coordinate.
//   cfg_* : register writes (cut length, side, axis, inner size). Write them
//           only while no transaction is in flight; the block does not enforce it.
// Steps:
//   Measure/emit: accept, row id multiply, row table read, update/result; a
//   kept entry shows on out_tvalid the cycle after. Begin: accept, epoch
//   advance. One transaction runs at a time, its steps in sequence. Rows out
//   of range skip read and update; unknown opcodes end after the row id step.
// Reset and wrap:
//   After rst_n the row table is swept clear, one row per cycle, with in_tready
//   low throughout. The 256th begin wraps the epoch and runs the same sweep.
// Stall:
//   One output register holds a result; new transactions are accepted while it
//   waits, but an emit stalls in its last cycle until that register frees.
module sparse_row_length_cutoff #(
  parameter int ROWS = srlc_pkg::SRLC_ROWS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // lead0[9:0], lead1[19:10], pos[35:20], tail[67:36], value[131:68], zero pad
  input  logic [srlc_pkg::SRLC_IN_W-1:0]      in_tdata,
  // opcode[1:0]
  input  srlc_pkg::srlc_op_t                  in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_lead0[9:0], out_lead1[19:10], new_pos[35:20], out_tail[67:36],
  // out_value[131:68], zero pad
  output logic [srlc_pkg::SRLC_OUT_W-1:0]     out_tdata,
  input  logic                                cfg_we,
  input  logic [srlc_pkg::SRLC_CFG_IDX_W-1:0] cfg_addr,
  input  logic [srlc_pkg::SRLC_CFG_W-1:0]     cfg_wdata
);
  import srlc_pkg::*;

  srlc_cmd_t cmd;
  srlc_sts_t sts;

  // sequencer: owns in_tready, paces each transaction
  srlc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: row table memory, epoch, cutoff compare, output register
  srlc_dp #(
    .ROWS (ROWS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

/* hw/rtl/srlc_chk.sv */
// Port-level checks for the sparse row length cutoff block, with bind.
module srlc_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [srlc_pkg::SRLC_OUT_W-1:0]   out_tdata
);

  // held result stays presented
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out_tdata changed while stalled");

  // one transaction at a time: no accept right after an accept
  a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("back-to-back input accept");

  // reset starts the clearing sweep
  a_rst_sweep: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input ready right after reset");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind sparse_row_length_cutoff srlc_chk u_srlc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
